@@ design/bsc_pkg.sv @@
// Shared types, widths and constants of the barometric sensor compensation pipeline.
`timescale 1ns / 1ps

package bsc_pkg;

  localparam int RAW_W    = 24;
  localparam int COEFF_W  = 16;
  localparam int IDX_W    = 3;
  localparam int DT_W     = 25;
  localparam int PROD_W   = 42;
  localparam int TEMP_W   = 19;
  localparam int OFF1_W   = 35;
  localparam int SENS1_W  = 34;
  localparam int TCORR_W  = 17;
  localparam int SQ_W     = 35;
  localparam int CORR_W   = 39;
  localparam int COMP_W   = 41;
  localparam int PW_W     = 37;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  localparam int TEMP_SHIFT  = 23;
  localparam int OFF_SHIFT   = 7;
  localparam int SENS_SHIFT  = 8;
  localparam int TSQ_SHIFT   = 31;
  localparam int P_SHIFT     = 21;
  localparam int OFF_SCALE   = 16;
  localparam int SENS_SCALE  = 15;
  localparam int REF_SCALE   = 8;

  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] VLOW_LIM  = 19'sd1500;

  typedef enum logic [IDX_W-1:0] {
    CFG_SENS,
    CFG_OFFSET,
    CFG_SENS_TC,
    CFG_OFFSET_TC,
    CFG_REF_TEMP,
    CFG_TEMP_SENS,
    CFG_SO_EN
  } cfg_idx_e;

  typedef struct packed {
    logic [COEFF_W-1:0] sens;
    logic [COEFF_W-1:0] offset;
    logic [COEFF_W-1:0] sens_tc;
    logic [COEFF_W-1:0] offset_tc;
    logic [COEFF_W-1:0] ref_temp;
    logic [COEFF_W-1:0] temp_sens;
    logic               so_en;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sens:      '0,
    offset:    '0,
    sens_tc:   '0,
    offset_tc: '0,
    ref_temp:  '0,
    temp_sens: '0,
    so_en:     1'b1
  };

  typedef struct packed {
    logic [RAW_W-1:0]   d1;
    logic [TEMP_W-1:0]  temp;
    logic [OFF1_W-1:0]  off1;
    logic [SENS1_W-1:0] sens1;
    logic [TCORR_W-1:0] tcorr;
  } fo_t;

  typedef struct packed {
    logic [RAW_W-1:0]  d1;
    logic [TEMP_W-1:0] temp_out;
    logic [COMP_W-1:0] off;
    logic [COMP_W-1:0] sens;
  } so_t;

endpackage

@@ design/bsc_cfg.sv @@
// Calibration and mode register file written through the configuration port.
`timescale 1ns / 1ps

module bsc_cfg import bsc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [IDX_W-1:0]   cfg_index_i,
  input  logic [COEFF_W-1:0] cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SENS:      cfg_d.sens      = cfg_data_i;
        CFG_OFFSET:    cfg_d.offset    = cfg_data_i;
        CFG_SENS_TC:   cfg_d.sens_tc   = cfg_data_i;
        CFG_OFFSET_TC: cfg_d.offset_tc = cfg_data_i;
        CFG_REF_TEMP:  cfg_d.ref_temp  = cfg_data_i;
        CFG_TEMP_SENS: cfg_d.temp_sens = cfg_data_i;
        CFG_SO_EN:     cfg_d.so_en     = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/bsc_first_order.sv @@
// First-order stages: temperature difference, coefficient products and scaled terms.
`timescale 1ns / 1ps

module bsc_first_order import bsc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [RAW_W-1:0] raw_pressure_i,
  input  logic [RAW_W-1:0] raw_temperature_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output fo_t              out_o
);

  logic rdy1, rdy2, rdy3;
  logic v1_q, v2_q, v3_q;

  logic [RAW_W-1:0]         d1_1_q, d1_2_q;
  logic signed [DT_W-1:0]   dt_d, dt_1_q;
  logic signed [PROD_W-1:0] pt_d, po_d, ps_d;
  logic signed [PROD_W-1:0] pt_2_q, po_2_q, ps_2_q;
  logic signed [2*DT_W-1:0] dtsq_d;
  logic [TCORR_W-1:0]       tcorr_2_q;
  logic signed [PROD_W-1:0] pt_bias, po_bias, ps_bias;
  fo_t                      fo_d, fo_q;

  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign dt_d = $signed({1'b0, raw_temperature_i})
              - $signed({1'b0, cfg_i.ref_temp, {REF_SCALE{1'b0}}});

  assign pt_d   = dt_1_q * $signed({1'b0, cfg_i.temp_sens});
  assign po_d   = dt_1_q * $signed({1'b0, cfg_i.offset_tc});
  assign ps_d   = dt_1_q * $signed({1'b0, cfg_i.sens_tc});
  assign dtsq_d = dt_1_q * dt_1_q;

  // Negative products get a bias so the shift truncates toward zero.
  assign pt_bias = pt_2_q + $signed({{(PROD_W-TEMP_SHIFT){1'b0}}, {TEMP_SHIFT{pt_2_q[PROD_W-1]}}});
  assign po_bias = po_2_q + $signed({{(PROD_W-OFF_SHIFT){1'b0}}, {OFF_SHIFT{po_2_q[PROD_W-1]}}});
  assign ps_bias = ps_2_q + $signed({{(PROD_W-SENS_SHIFT){1'b0}}, {SENS_SHIFT{ps_2_q[PROD_W-1]}}});

  always_comb begin
    fo_d.d1    = d1_2_q;
    fo_d.temp  = $signed(pt_bias[TEMP_SHIFT +: TEMP_W]) + TEMP_BASE;
    fo_d.off1  = $signed({{(OFF1_W-COEFF_W-OFF_SCALE){1'b0}}, cfg_i.offset, {OFF_SCALE{1'b0}}})
               + $signed(po_bias[OFF_SHIFT +: OFF1_W]);
    fo_d.sens1 = $signed({{(SENS1_W-COEFF_W-SENS_SCALE){1'b0}}, cfg_i.sens,
                          {SENS_SCALE{1'b0}}})
               + $signed(ps_bias[SENS_SHIFT +: SENS1_W]);
    fo_d.tcorr = tcorr_2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      d1_1_q <= raw_pressure_i;
      dt_1_q <= dt_d;
    end
    if (rdy2 && v1_q) begin
      d1_2_q    <= d1_1_q;
      pt_2_q    <= pt_d;
      po_2_q    <= po_d;
      ps_2_q    <= ps_d;
      tcorr_2_q <= dtsq_d[TSQ_SHIFT +: TCORR_W];
    end
    if (rdy3 && v2_q) begin
      fo_q <= fo_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_o       = fo_q;

endmodule

@@ design/bsc_second_order.sv @@
// Second-order stages: low-temperature squares, corrections and corrected offset and sensitivity.
`timescale 1ns / 1ps

module bsc_second_order import bsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  fo_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output so_t  out_o
);

  logic rdy4, rdy5, rdy6;
  logic v4_q, v5_q, v6_q;

  logic signed [TEMP_W-1:0]   temp, lo, vl;
  logic signed [2*TEMP_W-1:0] lo_sq_full, vl_sq_full;
  logic signed [TEMP_W:0]     temp_corr;
  logic                       low_d, vlow_d;
  logic [TEMP_W-1:0]          temp_out_d;

  logic [RAW_W-1:0]   d1_4_q, d1_5_q;
  logic [OFF1_W-1:0]  off1_4_q, off1_5_q;
  logic [SENS1_W-1:0] sens1_4_q, sens1_5_q;
  logic [TEMP_W-1:0]  temp_out_4_q, temp_out_5_q;
  logic [SQ_W-1:0]    lo_sq_4_q, vl_sq_4_q;
  logic               low_4_q, vlow_4_q;

  logic [SQ_W+2:0]    lo5, vl7;
  logic [SQ_W+3:0]    vl11;
  logic [CORR_W-1:0]  off2_d, sens2_d, off2_5_q, sens2_5_q;
  so_t                so_d, so_q;

  assign rdy6 = !v6_q || out_ready_i;
  assign rdy5 = !v5_q || rdy6;
  assign rdy4 = !v4_q || rdy5;
  assign in_ready_o = rdy4;

  assign temp       = $signed(in_i.temp);
  assign lo         = temp - TEMP_BASE;
  assign vl         = temp + VLOW_LIM;
  assign lo_sq_full = lo * lo;
  assign vl_sq_full = vl * vl;
  assign low_d      = cfg_i.so_en && (temp < TEMP_BASE);
  assign vlow_d     = temp < -VLOW_LIM;
  assign temp_corr  = {temp[TEMP_W-1], temp} - $signed({{(TEMP_W+1-TCORR_W){1'b0}}, in_i.tcorr});
  assign temp_out_d = low_d ? temp_corr[TEMP_W-1:0] : in_i.temp;

  assign lo5  = {3'b000, lo_sq_4_q} + {1'b0, lo_sq_4_q, 2'b00};
  assign vl7  = {vl_sq_4_q, 3'b000} - {3'b000, vl_sq_4_q};
  assign vl11 = {1'b0, vl_sq_4_q, 3'b000} + {3'b000, vl_sq_4_q, 1'b0} + {4'b0000, vl_sq_4_q};

  always_comb begin
    off2_d  = '0;
    sens2_d = '0;
    if (low_4_q) begin
      off2_d  = CORR_W'(lo5[SQ_W+2:1]) + (vlow_4_q ? CORR_W'(vl7) : '0);
      sens2_d = CORR_W'(lo5[SQ_W+2:2]) + (vlow_4_q ? CORR_W'(vl11[SQ_W+3:1]) : '0);
    end
  end

  always_comb begin
    so_d.d1       = d1_5_q;
    so_d.temp_out = temp_out_5_q;
    so_d.off      = $signed({{(COMP_W-OFF1_W){off1_5_q[OFF1_W-1]}}, off1_5_q})
                  - $signed({{(COMP_W-CORR_W){1'b0}}, off2_5_q});
    so_d.sens     = $signed({{(COMP_W-SENS1_W){sens1_5_q[SENS1_W-1]}}, sens1_5_q})
                  - $signed({{(COMP_W-CORR_W){1'b0}}, sens2_5_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy4) v4_q <= in_valid_i;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && in_valid_i) begin
      d1_4_q       <= in_i.d1;
      off1_4_q     <= in_i.off1;
      sens1_4_q    <= in_i.sens1;
      temp_out_4_q <= temp_out_d;
      lo_sq_4_q    <= lo_sq_full[SQ_W-1:0];
      vl_sq_4_q    <= vl_sq_full[SQ_W-1:0];
      low_4_q      <= low_d;
      vlow_4_q     <= vlow_d;
    end
    if (rdy5 && v4_q) begin
      d1_5_q       <= d1_4_q;
      off1_5_q     <= off1_4_q;
      sens1_5_q    <= sens1_4_q;
      temp_out_5_q <= temp_out_4_q;
      off2_5_q     <= off2_d;
      sens2_5_q    <= sens2_d;
    end
    if (rdy6 && v5_q) begin
      so_q <= so_d;
    end
  end

  assign out_valid_o = v6_q;
  assign out_o       = so_q;

endmodule

@@ design/bsc_pressure.sv @@
// Pressure stages: split sensitivity product, truncating scale and saturating offset removal.
`timescale 1ns / 1ps

module bsc_pressure import bsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  so_t               in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [TEMP_W-1:0] temperature_centi_o,
  output logic [PW_W-1:0]   pressure_word_o
);

  localparam int PLO_W = RAW_W + P_SHIFT;
  localparam int PHI_W = RAW_W + 1 + COMP_W - P_SHIFT;
  localparam int Q_W   = PHI_W + 1;
  localparam int PW47_W = Q_W + 1;

  logic rdy7, rdy8, rdy9;
  logic v7_q, v8_q, v9_q;

  logic [PLO_W-1:0]         p_lo_d, p_lo_7_q;
  logic signed [PHI_W-1:0]  p_hi_d, p_hi_7_q;
  logic                     neg_7_q;
  logic [COMP_W-1:0]        off_7_q, off_8_q;
  logic [TEMP_W-1:0]        temp_7_q, temp_8_q, temp_9_q;
  logic signed [Q_W-1:0]    q_d, q_8_q;
  logic signed [PW47_W-1:0] pw_full;
  logic [PW_W-1:0]          pw_d, pw_9_q;

  assign rdy9 = !v9_q || out_ready_i;
  assign rdy8 = !v8_q || rdy9;
  assign rdy7 = !v7_q || rdy8;
  assign in_ready_o = rdy7;

  assign p_lo_d = in_i.d1 * in_i.sens[P_SHIFT-1:0];
  assign p_hi_d = $signed({1'b0, in_i.d1}) * $signed(in_i.sens[COMP_W-1:P_SHIFT]);

  // The low product is non-negative, so the quotient is the high product plus the carried
  // low part, moved up by one when a negative result has a nonzero remainder.
  assign q_d = $signed({p_hi_7_q[PHI_W-1], p_hi_7_q})
             + $signed({{(Q_W-RAW_W){1'b0}}, p_lo_7_q[PLO_W-1:P_SHIFT]})
             + $signed({{(Q_W-1){1'b0}}, neg_7_q && (|p_lo_7_q[P_SHIFT-1:0])});

  assign pw_full = $signed({q_8_q[Q_W-1], q_8_q})
                 - $signed({{(PW47_W-COMP_W){off_8_q[COMP_W-1]}}, off_8_q});

  always_comb begin
    if (pw_full[PW47_W-1:PW_W-1] == '0 || pw_full[PW47_W-1:PW_W-1] == '1) begin
      pw_d = pw_full[PW_W-1:0];
    end else if (pw_full[PW47_W-1]) begin
      pw_d = {1'b1, {(PW_W-1){1'b0}}};
    end else begin
      pw_d = {1'b0, {(PW_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      if (rdy7) v7_q <= in_valid_i;
      if (rdy8) v8_q <= v7_q;
      if (rdy9) v9_q <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy7 && in_valid_i) begin
      p_lo_7_q <= p_lo_d;
      p_hi_7_q <= p_hi_d;
      neg_7_q  <= in_i.sens[COMP_W-1];
      off_7_q  <= in_i.off;
      temp_7_q <= in_i.temp_out;
    end
    if (rdy8 && v7_q) begin
      q_8_q    <= q_d;
      off_8_q  <= off_7_q;
      temp_8_q <= temp_7_q;
    end
    if (rdy9 && v8_q) begin
      pw_9_q   <= pw_d;
      temp_9_q <= temp_8_q;
    end
  end

  assign out_valid_o         = v9_q;
  assign temperature_centi_o = temp_9_q;
  assign pressure_word_o     = pw_9_q;

endmodule

@@ design/baro_sensor_compensation.sv @@
// An accepted input transaction reaches m_axis_tvalid through the nine register stages of
// the multiply, square and scaling path.
// Throughput: one transaction per cycle; a low m_axis_tready holds the last stage, and earlier
// stages advance only into slots that are empty or being vacated.
// Reset clears all stage valid bits and loads the calibration words with zero and the
// second-order enable with one; no clearing pass follows.
`timescale 1ns / 1ps

module baro_sensor_compensation import bsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [IDX_W-1:0]      cfg_index_i,
  input  logic [COEFF_W-1:0]    cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: raw_pressure[23:0], raw_temperature[47:24].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: temperature_centi[18:0], pressure_word[55:19].
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  cfg_t              cfg;
  fo_t               fo;
  so_t               so;
  logic              fo_valid, fo_ready, so_valid, so_ready;
  logic [TEMP_W-1:0] temperature_centi;
  logic [PW_W-1:0]   pressure_word;

  bsc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  bsc_first_order u_first (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .raw_pressure_i    (s_axis_tdata[RAW_W-1:0]),
    .raw_temperature_i (s_axis_tdata[2*RAW_W-1:RAW_W]),
    .out_valid_o       (fo_valid),
    .out_ready_i       (fo_ready),
    .out_o             (fo)
  );

  bsc_second_order u_second (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (fo_valid),
    .in_ready_o  (fo_ready),
    .in_i        (fo),
    .out_valid_o (so_valid),
    .out_ready_i (so_ready),
    .out_o       (so)
  );

  bsc_pressure u_pressure (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (so_valid),
    .in_ready_o          (so_ready),
    .in_i                (so),
    .out_valid_o         (m_axis_tvalid),
    .out_ready_i         (m_axis_tready),
    .temperature_centi_o (temperature_centi),
    .pressure_word_o     (pressure_word)
  );

  assign m_axis_tdata = {pressure_word, temperature_centi};

endmodule
